// ----- rtl/core/ezsd_pkg.sv -----
// Shared types, register codes and constants of the speech endpoint detector.
// Used by every module of the block; the channel interface gets its payload types from it.
`timescale 1ns / 1ps
`default_nettype none

package ezsd_pkg;

   // Frame length in samples
   localparam int FRAME_SAMPLES_DEFAULT = 32;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int ENERGY_W   = 19;
   localparam int COUNT8_W   = 8;
   localparam int COUNT16_W  = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // Quotient by 1000: floor(abs * RECIP_MULT >> RECIP_SHIFT) is exact
   // for every 16-bit magnitude
   localparam int             QMAG_W      = 6;
   localparam int             RECIP_W     = 17;
   localparam int             PROD_W      = SAMPLE_W + RECIP_W;
   localparam int             RECIP_SHIFT = 26;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd67109;
   localparam int             SQ_W        = 2 * QMAG_W;

   // Saturation limits
   localparam logic [ENERGY_W-1:0]  ENERGY_MAX  = '1;
   localparam logic [COUNT8_W-1:0]  COUNT8_MAX  = '1;
   localparam logic [COUNT16_W-1:0] COUNT16_MAX = '1;

   // Register reset values
   localparam logic [15:0] ENERGY_HIGH_RST  = 16'd3;
   localparam logic [15:0] ENERGY_LOW_RST   = 16'd2;
   localparam logic [7:0]  CROSSING_THR_RST = 8'd6;
   localparam logic [15:0] SILENCE_LIM_RST  = 16'd400;
   localparam logic [15:0] MIN_LENGTH_RST   = 16'd450;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENERGY_HIGH  = 3'd0,
      CSR_ENERGY_LOW   = 3'd1,
      CSR_CROSSING_THR = 3'd2,
      CSR_SILENCE_LIM  = 3'd3,
      CSR_MIN_LENGTH   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      DEC_DROP = 2'd0,
      DEC_KEEP = 2'd1,
      DEC_DONE = 2'd2
   } decision_type;

   typedef enum logic [1:0] {
      PH_SILENCE = 2'd0,
      PH_MAYBE   = 2'd1,
      PH_SPEECH  = 2'd2
   } phase_type;

   // Channel payloads
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      decision_type          decision;
      logic [ENERGY_W-1:0]   frame_energy;
      logic [COUNT8_W-1:0]   frame_crossings;
      logic [COUNT16_W-1:0]  kept_frames;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type          index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_payload_type;

   // Register file contents
   typedef struct packed {
      logic [15:0] energy_high;
      logic [15:0] energy_low;
      logic [7:0]  crossing_threshold;
      logic [15:0] silence_limit;
      logic [15:0] min_length;
   } cfg_type;

   // Quantized sample: magnitude of sample/1000 and strict sign flags
   typedef struct packed {
      logic [QMAG_W-1:0] mag;
      logic              pos;
      logic              neg;
   } quant_type;

   // Totals of one finished frame
   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [COUNT8_W-1:0] crossings;
   } frame_type;

endpackage

`default_nettype wire

// ----- rtl/core/ezsd_chan_if.sv -----
// Valid/ready channel carrying one payload struct per request.
// Payload type comes from ezsd_pkg at the point of instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface ezsd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/energy_zcr_speech_endpoint_detector.sv -----
// Speech endpoint detector. Takes one signed 16-bit sample per cycle; every
// FRAME_SAMPLES samples it emits one decision (drop, keep, done) with the
// frame's energy, zero crossing count and the kept-frame count. Each stage is
// a register with its own valid/ready, so a sample is taken every cycle while
// the result register can still move; once the last sample of a frame is in the
// input register, it passes the quotient-by-1000 register, the frame totals and
// the decision register, which offers the result. Registers are written through
// the csr channel and should only change while no frame is in flight.
// Depends on ezsd_pkg, ezsd_chan_if and the ezsd_* stage modules.
`timescale 1ns / 1ps
`default_nettype none

module energy_zcr_speech_endpoint_detector #(
   parameter int FRAME_SAMPLES = ezsd_pkg::FRAME_SAMPLES_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ezsd_chan_if.sink   req_chan,
   ezsd_chan_if.source rsp_chan,
   ezsd_chan_if.sink   csr_chan
);

   ezsd_pkg::cfg_type   cfg;
   logic                q_valid;
   logic                q_ready;
   ezsd_pkg::quant_type q_data;
   logic                f_valid;
   logic                f_ready;
   ezsd_pkg::frame_type f_data;

   // Configuration registers
   ezsd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .wr_valid   (csr_chan.valid),
      .wr_ready   (csr_chan.ready),
      .wr_payload (csr_chan.payload),
      .cfg        (cfg)
   );

   // Input register and quantizer
   ezsd_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_sample (req_chan.payload.sample),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_quant (q_data)
   );

   // Frame totals
   ezsd_frame #(
      .FRAME_SAMPLES (FRAME_SAMPLES)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_quant  (q_data),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_frame (f_data)
   );

   // Decision machine and result register
   ezsd_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (f_valid),
      .in_ready    (f_ready),
      .in_frame    (f_data),
      .cfg         (cfg),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

`default_nettype wire

// ----- rtl/core/ezsd_csr.sv -----
// Configuration register file of the endpoint detector.
// Depends on ezsd_pkg for register codes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module ezsd_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_valid,
   output logic                         wr_ready,
   input  wire ezsd_pkg::csr_payload_type wr_payload,
   output ezsd_pkg::cfg_type            cfg
);

   ezsd_pkg::cfg_type cfg_ff;
   ezsd_pkg::cfg_type cfg_in;

   // Writes are always taken
   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   // Decode the register index; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_payload.index)
            ezsd_pkg::CSR_ENERGY_HIGH:  cfg_in.energy_high        = wr_payload.data;
            ezsd_pkg::CSR_ENERGY_LOW:   cfg_in.energy_low         = wr_payload.data;
            ezsd_pkg::CSR_CROSSING_THR: cfg_in.crossing_threshold = wr_payload.data[7:0];
            ezsd_pkg::CSR_SILENCE_LIM:  cfg_in.silence_limit      = wr_payload.data;
            ezsd_pkg::CSR_MIN_LENGTH:   cfg_in.min_length         = wr_payload.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_high        <= ezsd_pkg::ENERGY_HIGH_RST;
         cfg_ff.energy_low         <= ezsd_pkg::ENERGY_LOW_RST;
         cfg_ff.crossing_threshold <= ezsd_pkg::CROSSING_THR_RST;
         cfg_ff.silence_limit      <= ezsd_pkg::SILENCE_LIM_RST;
         cfg_ff.min_length         <= ezsd_pkg::MIN_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ezsd_quant.sv -----
// Input register and quantizer: sample/1000 truncated, by reciprocal multiply.
// Depends on ezsd_pkg for widths, the reciprocal constant and quant_type.
`timescale 1ns / 1ps
`default_nettype none

module ezsd_quant (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [ezsd_pkg::SAMPLE_W-1:0] in_sample,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output ezsd_pkg::quant_type               out_quant
);

   logic                          s0_valid_ff, s0_valid_in;
   logic [ezsd_pkg::SAMPLE_W-1:0] sample_ff;
   logic                          s1_valid_ff, s1_valid_in;
   ezsd_pkg::quant_type           quant_ff, quant_in;
   logic                          s1_ready;
   logic [ezsd_pkg::SAMPLE_W-1:0] abs_val;
   logic [ezsd_pkg::PROD_W-1:0]   prod;

   // Stage handshakes
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign in_ready  = !s0_valid_ff || s1_ready;
   assign out_valid = s1_valid_ff;
   assign out_quant = quant_ff;

   // Magnitude, quotient by 1000 and strict sign flags
   always_comb begin
      abs_val      = sample_ff[ezsd_pkg::SAMPLE_W-1] ? (~sample_ff + 16'd1) : sample_ff;
      prod         = ezsd_pkg::PROD_W'(abs_val) * ezsd_pkg::PROD_W'(ezsd_pkg::RECIP_MULT);
      quant_in.mag = prod[ezsd_pkg::RECIP_SHIFT +: ezsd_pkg::QMAG_W];
      quant_in.neg = sample_ff[ezsd_pkg::SAMPLE_W-1];
      quant_in.pos = !sample_ff[ezsd_pkg::SAMPLE_W-1] && (sample_ff != '0);
   end

   // Advance valid flags
   always_comb begin
      s0_valid_in = in_ready ? in_valid : s0_valid_ff;
      s1_valid_in = s1_ready ? s0_valid_ff : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sample_ff <= in_sample;
      end
      if (s0_valid_ff && s1_ready) begin
         quant_ff <= quant_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ezsd_frame.sv -----
// Frame accumulator: saturating energy sum and qualified zero crossings.
// Depends on ezsd_pkg for quant_type, frame_type and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module ezsd_frame #(
   parameter int FRAME_SAMPLES = ezsd_pkg::FRAME_SAMPLES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire ezsd_pkg::quant_type in_quant,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ezsd_pkg::frame_type      out_frame
);

   localparam int POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_SAMPLES - 1);

   logic [POS_W-1:0]              pos_ff, pos_in;
   ezsd_pkg::quant_type           prev_ff, prev_in;
   logic [ezsd_pkg::ENERGY_W-1:0] energy_ff, energy_in;
   logic [ezsd_pkg::COUNT8_W-1:0] cross_ff, cross_in;
   logic                          fe_valid_ff, fe_valid_in;
   ezsd_pkg::frame_type           fe_ff, fe_in;
   logic                          accept;
   logic                          last;
   logic                          crossing;
   logic [ezsd_pkg::SQ_W-1:0]     sq;
   logic [ezsd_pkg::ENERGY_W:0]   sum;
   logic [ezsd_pkg::ENERGY_W-1:0] energy_sat;
   logic [ezsd_pkg::COUNT8_W-1:0] cross_upd;

   assign in_ready  = !fe_valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign last      = (pos_ff == POS_LAST);
   assign out_valid = fe_valid_ff;
   assign out_frame = fe_ff;

   // Accumulate energy and crossings of the current sample
   always_comb begin
      sq         = ezsd_pkg::SQ_W'(in_quant.mag) * ezsd_pkg::SQ_W'(in_quant.mag);
      sum        = {1'b0, energy_ff} + (ezsd_pkg::ENERGY_W + 1)'(sq);
      energy_sat = sum[ezsd_pkg::ENERGY_W] ? ezsd_pkg::ENERGY_MAX
                                          : sum[ezsd_pkg::ENERGY_W-1:0];
      // Opposite signs always differ in quotient unless both quotients are zero
      crossing   = ((prev_ff.neg && in_quant.pos) || (prev_ff.pos && in_quant.neg))
                   && ((prev_ff.mag != '0) || (in_quant.mag != '0));
      cross_upd  = (crossing && (cross_ff != ezsd_pkg::COUNT8_MAX)) ? cross_ff + 8'd1
                                                                   : cross_ff;
   end

   // Advance position; close the frame on its last sample
   always_comb begin
      pos_in      = pos_ff;
      prev_in     = prev_ff;
      energy_in   = energy_ff;
      cross_in    = cross_ff;
      fe_valid_in = fe_valid_ff && !out_ready;
      fe_in       = fe_ff;
      if (accept) begin
         prev_in = in_quant;
         if (last) begin
            pos_in          = '0;
            energy_in       = '0;
            cross_in        = '0;
            fe_valid_in     = 1'b1;
            fe_in.energy    = energy_sat;
            fe_in.crossings = cross_upd;
         end else begin
            pos_in    = pos_ff + POS_W'(1);
            energy_in = energy_sat;
            cross_in  = cross_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         prev_ff     <= '0;
         energy_ff   <= '0;
         cross_ff    <= '0;
         fe_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         prev_ff     <= prev_in;
         energy_ff   <= energy_in;
         cross_ff    <= cross_in;
         fe_valid_ff <= fe_valid_in;
      end
   end

   // Hold frame totals until taken
   always_ff @(posedge clock) begin
      fe_ff <= fe_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/ezsd_phase.sv -----
// Silence / maybe / speech decision machine and the result register.
// Depends on ezsd_pkg for phase and decision codes, cfg_type and payload types.
`timescale 1ns / 1ps
`default_nettype none

module ezsd_phase (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire ezsd_pkg::frame_type   in_frame,
   input  wire ezsd_pkg::cfg_type     cfg,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ezsd_pkg::rsp_payload_type  rsp_payload
);

   ezsd_pkg::phase_type            phase_ff, phase_in;
   logic [ezsd_pkg::COUNT16_W-1:0] quiet_ff, quiet_in;
   logic [ezsd_pkg::COUNT16_W-1:0] utt_ff, utt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ezsd_pkg::rsp_payload_type      rsp_ff, rsp_in;
   logic                           take;
   logic                           loud;
   logic                           active;
   logic [ezsd_pkg::COUNT16_W-1:0] quiet_inc;
   logic [ezsd_pkg::COUNT16_W-1:0] utt_inc;
   ezsd_pkg::decision_type         decision;
   logic [ezsd_pkg::COUNT16_W-1:0] kept;

   function automatic logic [ezsd_pkg::COUNT16_W-1:0] sat_inc16(
      input logic [ezsd_pkg::COUNT16_W-1:0] v
   );
      return (v != ezsd_pkg::COUNT16_MAX) ? v + 16'd1 : v;
   endfunction

   assign in_ready    = !rsp_valid_ff || rsp_ready;
   assign take        = in_valid && in_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Classify the frame
   always_comb begin
      loud      = in_frame.energy > ezsd_pkg::ENERGY_W'(cfg.energy_high);
      active    = (in_frame.energy > ezsd_pkg::ENERGY_W'(cfg.energy_low))
                  || (in_frame.crossings > cfg.crossing_threshold);
      quiet_inc = sat_inc16(quiet_ff);
      utt_inc   = sat_inc16(utt_ff);
   end

   // Next phase, counters and decision
   always_comb begin
      phase_in = phase_ff;
      quiet_in = quiet_ff;
      utt_in   = utt_ff;
      decision = ezsd_pkg::DEC_DROP;
      kept     = utt_ff;
      if (take) begin
         case (phase_ff)
            ezsd_pkg::PH_SPEECH: begin
               if (active) begin
                  utt_in   = utt_inc;
                  decision = ezsd_pkg::DEC_KEEP;
                  kept     = utt_inc;
               end else if (quiet_inc < cfg.silence_limit) begin
                  quiet_in = quiet_inc;
                  utt_in   = utt_inc;
                  decision = ezsd_pkg::DEC_KEEP;
                  kept     = utt_inc;
               end else begin
                  // Utterance over: drop if too short, else report done
                  decision = (utt_ff < cfg.min_length) ? ezsd_pkg::DEC_DROP
                                                       : ezsd_pkg::DEC_DONE;
                  kept     = (utt_ff < cfg.min_length) ? '0 : utt_ff;
                  phase_in = ezsd_pkg::PH_SILENCE;
                  quiet_in = '0;
                  utt_in   = '0;
               end
            end
            // Silence, maybe and the unused code behave alike
            default: begin
               if (loud) begin
                  phase_in = ezsd_pkg::PH_SPEECH;
                  quiet_in = '0;
                  utt_in   = utt_inc;
                  decision = ezsd_pkg::DEC_KEEP;
                  kept     = utt_inc;
               end else if (active) begin
                  phase_in = ezsd_pkg::PH_MAYBE;
                  utt_in   = utt_inc;
                  decision = ezsd_pkg::DEC_KEEP;
                  kept     = utt_inc;
               end else begin
                  phase_in = ezsd_pkg::PH_SILENCE;
                  utt_in   = '0;
                  decision = ezsd_pkg::DEC_DROP;
                  kept     = '0;
               end
            end
         endcase
      end
   end

   // Load the result register
   always_comb begin
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_in.decision        = decision;
         rsp_in.frame_energy    = in_frame.energy;
         rsp_in.frame_crossings = in_frame.crossings;
         rsp_in.kept_frames     = kept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ezsd_pkg::PH_SILENCE;
         quiet_ff     <= '0;
         utt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         quiet_ff     <= quiet_in;
         utt_ff       <= utt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- verif/energy_zcr_speech_endpoint_detector_tb.sv -----
// Self-checking testbench for energy_zcr_speech_endpoint_detector: frame patterns
// and random utterances are checked against a cycle-free predictor of the detector.
// Depends on ezsd_pkg, ezsd_chan_if and the detector RTL.
`timescale 1ns / 1ps

module energy_zcr_speech_endpoint_detector_tb;
   import ezsd_pkg::*;

   localparam int FRAME       = FRAME_SAMPLES_DEFAULT;
   localparam int PIPE_SETTLE = 6;
   localparam int STALL_LIMIT = 2000;

   typedef enum {FR_QUIET, FR_FAINT, FR_LOUD, FR_CHATTER, FR_NOISE} frame_shape_type;

   // One row of the directed plan: a register write, or a frame of two
   // alternating samples with an optional hand-written decision
   typedef struct {
      bit              is_write;
      csr_index_type   idx;
      logic [15:0]     data;
      logic [15:0]     even_s;
      logic [15:0]     odd_s;
      bit              typed;
      rsp_payload_type want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset;

   ezsd_chan_if #(.payload_type(req_payload_type)) req_if ();
   ezsd_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   ezsd_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   energy_zcr_speech_endpoint_detector #(.FRAME_SAMPLES(FRAME)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #2 clock = ~clock;

   // Detector shadow state and thresholds
   cfg_type              thresholds;
   int                   frame_pos;
   logic signed [15:0]   prev_sample;
   logic [ENERGY_W-1:0]  energy_acc;
   logic [COUNT8_W-1:0]  cross_acc;
   phase_type            det_phase;
   logic [15:0]          quiet_cnt;
   logic [15:0]          kept_cnt;

   rsp_payload_type decisions_due[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatch_count = 0;
   int frames_checked = 0;
   int samples_sent = 0;
   int frames_sent = 0;
   int csr_writes = 0;
   int stall_cycles = 0;

   task automatic flag(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == COUNT16_MAX) ? v : v + 16'd1;
   endfunction

   // Advance the detector by one sample; on the last sample of a frame
   // produce its decision
   task automatic advance_detector(input logic [15:0] raw, output bit emitted,
                                   output rsp_payload_type res);
      int           s, q, qp, e;
      bit           opposite, loud, active;
      logic [18:0]  fe;
      logic [7:0]   fc;
      decision_type d;
      s  = int'($signed(raw));
      q  = s / 1000;
      qp = int'(prev_sample) / 1000;
      e  = int'(energy_acc) + q * q;
      energy_acc = (e > int'(ENERGY_MAX)) ? ENERGY_MAX : ENERGY_W'(e);
      opposite = (prev_sample < 0 && s > 0) || (prev_sample > 0 && s < 0);
      if (opposite && q != qp && cross_acc != COUNT8_MAX)
         cross_acc++;
      prev_sample = raw;
      emitted = 1'b0;
      res = '0;
      frame_pos++;
      if (frame_pos < FRAME)
         return;

      fe = energy_acc;
      fc = cross_acc;
      frame_pos = 0;
      energy_acc = '0;
      cross_acc = '0;
      loud = fe > ENERGY_W'(thresholds.energy_high);
      active = (fe > ENERGY_W'(thresholds.energy_low)) ||
               (fc > thresholds.crossing_threshold);

      if (det_phase == PH_SPEECH) begin
         if (active) begin
            kept_cnt = bump16(kept_cnt);
            d = DEC_KEEP;
         end else begin
            quiet_cnt = bump16(quiet_cnt);
            if (quiet_cnt < thresholds.silence_limit) begin
               kept_cnt = bump16(kept_cnt);
               d = DEC_KEEP;
            end else if (kept_cnt < thresholds.min_length) begin
               kept_cnt = '0;
               d = DEC_DROP;
            end else begin
               d = DEC_DONE;
            end
         end
      end else if (loud) begin
         det_phase = PH_SPEECH;
         quiet_cnt = '0;
         kept_cnt = bump16(kept_cnt);
         d = DEC_KEEP;
      end else if (active) begin
         det_phase = PH_MAYBE;
         kept_cnt = bump16(kept_cnt);
         d = DEC_KEEP;
      end else begin
         det_phase = PH_SILENCE;
         kept_cnt = '0;
         d = DEC_DROP;
      end

      res.decision = d;
      res.frame_energy = fe;
      res.frame_crossings = fc;
      res.kept_frames = kept_cnt;
      // End of utterance: back to silence with counters cleared
      if (det_phase == PH_SPEECH && d != DEC_KEEP) begin
         det_phase = PH_SILENCE;
         quiet_cnt = '0;
         kept_cnt = '0;
      end
      emitted = 1'b1;
   endtask

   // Send one sample request; queue the decision it closes, if any
   task automatic push_sample(input logic [15:0] s, input bit typed,
                              input rsp_payload_type want);
      bit              emitted;
      rsp_payload_type res;
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.payload.sample = s;
      do @(posedge clock); while (!req_if.ready);
      advance_detector(s, emitted, res);
      if (emitted)
         decisions_due.push_back(typed ? want : res);
      samples_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued decision is out and the pipe drains
   task automatic settle();
      req_if.valid = 1'b0;
      while (decisions_due.size() != 0)
         @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      settle();
      csr_if.valid = 1'b1;
      csr_if.payload.index = idx;
      csr_if.payload.data = data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_ENERGY_HIGH:  thresholds.energy_high = data;
         CSR_ENERGY_LOW:   thresholds.energy_low = data;
         CSR_CROSSING_THR: thresholds.crossing_threshold = data[7:0];
         CSR_SILENCE_LIM:  thresholds.silence_limit = data;
         CSR_MIN_LENGTH:   thresholds.min_length = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic apply_thresholds(input logic [15:0] eh, input logic [15:0] el,
                                   input logic [7:0] ct, input logic [15:0] sl,
                                   input logic [15:0] ml);
      write_reg(CSR_ENERGY_HIGH, eh);
      write_reg(CSR_ENERGY_LOW, el);
      write_reg(CSR_CROSSING_THR, {8'd0, ct});
      write_reg(CSR_SILENCE_LIM, sl);
      write_reg(CSR_MIN_LENGTH, ml);
   endtask

   task automatic random_thresholds();
      logic [15:0] eh;
      eh = 16'($urandom_range(4, 60));
      apply_thresholds(eh, 16'($urandom_range(0, eh)), 8'($urandom_range(0, 24)),
                       16'($urandom_range(0, 2)), 16'($urandom_range(0, 8)));
   endtask

   function automatic logic [15:0] shaped_sample(input frame_shape_type k, input int idx);
      int m;
      case (k)
         FR_QUIET:
            m = int'($urandom_range(0, 1998)) - 999;
         FR_FAINT:
            if ($urandom_range(5) == 0) begin
               m = $urandom_range(1000, 2999);
               if ($urandom_range(1)) m = -m;
            end else begin
               m = int'($urandom_range(0, 1998)) - 999;
            end
         FR_LOUD: begin
            if ($urandom_range(63) == 0)
               return 16'h8000;
            m = $urandom_range(1000, 32767);
            if ($urandom_range(1)) m = -m;
         end
         FR_CHATTER:
            m = (idx % 2 == 0) ? int'($urandom_range(1, 1999))
                               : -int'($urandom_range(1000, 1999));
         default:
            return 16'($urandom_range(0, 65535));
      endcase
      return 16'(m);
   endfunction

   task automatic send_frame(input frame_shape_type k);
      for (int i = 0; i < FRAME; i++)
         push_sample(shaped_sample(k, i), 1'b0, '0);
      frames_sent++;
   endtask

   // Lead-in, body, then a short quiet tail that closes the utterance
   // when the silence limit is small
   task automatic send_utterance();
      int tail;
      frame_shape_type body_pick[4];
      body_pick = '{FR_LOUD, FR_CHATTER, FR_FAINT, FR_QUIET};
      repeat ($urandom_range(0, 1))
         send_frame($urandom_range(1) ? FR_FAINT : FR_CHATTER);
      repeat ($urandom_range(1, 2))
         send_frame(body_pick[$urandom_range(3)]);
      tail = int'(thresholds.silence_limit) + int'($urandom_range(0, 1));
      if (tail > 2) tail = 2;
      repeat (tail)
         send_frame(FR_QUIET);
   endtask

   task automatic run_segment(input int frame_goal);
      int start;
      start = frames_sent;
      while (frames_sent - start < frame_goal) begin
         if ($urandom_range(9) < 8)
            send_utterance();
         else
            send_frame($urandom_range(1) ? FR_NOISE : FR_QUIET);
      end
   endtask

   // Receiver backpressure
   always @(negedge clock)
      rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);

   // Compare each decision with the oldest one expected
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (decisions_due.size() == 0) begin
            flag("decision with none pending", rsp_if.payload.decision, -1);
         end else begin
            want = decisions_due.pop_front();
            if (rsp_if.payload.decision !== want.decision)
               flag("decision", rsp_if.payload.decision, want.decision);
            if (rsp_if.payload.frame_energy !== want.frame_energy)
               flag("frame_energy", rsp_if.payload.frame_energy, want.frame_energy);
            if (rsp_if.payload.frame_crossings !== want.frame_crossings)
               flag("frame_crossings", rsp_if.payload.frame_crossings,
                    want.frame_crossings);
            if (rsp_if.payload.kept_frames !== want.kept_frames)
               flag("kept_frames", rsp_if.payload.kept_frames, want.kept_frames);
            frames_checked++;
         end
      end
   end

   // Watchdog: end the run when no request moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      step_row_type plan [20];
      rsp_payload_type none;
      none = '0;
      plan = '{
         // quiet and sub-threshold frames after reset
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'd0, 16'd0, 1'b1,
           '{DEC_DROP, 19'd0, 8'd0, 16'd0}},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'sd999, -16'sd999, 1'b1,
           '{DEC_DROP, 19'd0, 8'd0, 16'd0}},
         // full-scale alternation starts speech
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'h7FFF, 16'h8000, 1'b1,
           '{DEC_KEEP, 19'd32768, 8'd32, 16'd1}},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, -16'sd1, -16'sd1, 1'b1,
           '{DEC_KEEP, 19'd0, 8'd0, 16'd2}},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'sd1000, -16'sd1000, 1'b1,
           '{DEC_KEEP, 19'd32, 8'd32, 16'd3}},
         // zero silence limit: first quiet frame ends a short utterance
         '{1'b1, CSR_SILENCE_LIM, 16'd0, 16'd0, 16'd0, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'd0, 16'd0, 1'b1,
           '{DEC_DROP, 19'd0, 8'd0, 16'd0}},
         '{1'b1, CSR_MIN_LENGTH, 16'd0, 16'd0, 16'd0, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'sd5000, 16'sd5000, 1'b1,
           '{DEC_KEEP, 19'd800, 8'd0, 16'd1}},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'd0, 16'd0, 1'b1,
           '{DEC_DONE, 19'd0, 8'd0, 16'd1}},
         // crossings alone reach maybe, then loud, then done
         '{1'b1, CSR_ENERGY_HIGH, 16'd100, 16'd0, 16'd0, 1'b0, none},
         '{1'b1, CSR_ENERGY_LOW, 16'd40, 16'd0, 16'd0, 1'b0, none},
         '{1'b1, CSR_CROSSING_THR, 16'd20, 16'd0, 16'd0, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'sd1000, -16'sd999, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'sd2000, -16'sd2000, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'd0, 16'd0, 1'b0, none},
         // out-of-range register writes leave thresholds alone
         '{1'b1, csr_index_type'(3'd5), 16'd0, 16'd0, 16'd0, 1'b0, none},
         '{1'b1, csr_index_type'(3'd7), 16'hFFFF, 16'd0, 16'd0, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'sd999, -16'sd1000, 1'b0, none},
         '{1'b0, CSR_ENERGY_HIGH, 16'd0, 16'd0, 16'd0, 1'b0, none}
      };

      // Hold every input at a known value through reset
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '{CSR_ENERGY_HIGH, 16'd0};
      rsp_if.ready = 1'b0;

      thresholds = '{ENERGY_HIGH_RST, ENERGY_LOW_RST, CROSSING_THR_RST,
                     SILENCE_LIM_RST, MIN_LENGTH_RST};
      frame_pos = 0;
      prev_sample = '0;
      energy_acc = '0;
      cross_acc = '0;
      det_phase = PH_SILENCE;
      quiet_cnt = '0;
      kept_cnt = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed plan, sender mostly busy and receiver mostly stalled
      req_idle_pct = 6;
      rsp_idle_pct = 70;
      foreach (plan[r]) begin
         if (plan[r].is_write) begin
            write_reg(plan[r].idx, plan[r].data);
         end else begin
            for (int i = 0; i < FRAME; i++)
               push_sample((i % 2 == 0) ? plan[r].even_s : plan[r].odd_s,
                           plan[r].typed, plan[r].want);
            frames_sent++;
         end
      end

      // Random utterances, sender mostly idle
      req_idle_pct = 70;
      rsp_idle_pct = 6;
      random_thresholds();
      run_segment(2);

      // Threshold extremes and random settings at full rate
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      apply_thresholds(16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
      run_segment(1);
      apply_thresholds(16'd32768, 16'd32768, 8'd255, 16'hFFFF, 16'hFFFF);
      send_frame(FR_LOUD);
      send_frame(FR_NOISE);
      random_thresholds();
      run_segment(1);

      // Drain and report
      settle();
      $display("sent %0d samples in %0d frames with %0d register writes",
               samples_sent, frames_sent, csr_writes);
      $display("checked %0d frame decisions, %0d mismatches",
               frames_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
